// ===== rtl/core/sgb_pkg.sv =====
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared constants for the separable Gaussian blur core.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int RADIUS_DEF     = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int ROWS_KEPT      = 8;

  localparam int PIX_W   = 16;
  localparam int DIM_W   = 11;
  localparam int COEFF_W = 16;
  localparam int POS_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_DATA_W = 40;

  localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd1024;
  localparam logic [COEFF_W-1:0] C0_RST     = 16'd17430;
  localparam logic [COEFF_W-1:0] C1_RST     = 16'd13956;
  localparam logic [COEFF_W-1:0] C2_RST     = 16'd7166;
  localparam logic [COEFF_W-1:0] C3_RST     = 16'd2359;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_C0     = 3'd2,
    REG_C1     = 3'd3,
    REG_C2     = 3'd4,
    REG_C3     = 3'd5
  } cfg_reg_t;

endpackage

// ===== rtl/core/separable_gaussian_blur_top.sv =====
// ----------------------------------------------------------------------------
// separable_gaussian_blur_top
// Separable Gaussian blur, clamped borders, eight-row line store in one RAM.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Payload
// --------+-----+--------------------------------------------------------
// in_*    | in  | tdata: pixel[15:0]; tuser: kind (1 = drain)
// out_*   | out | tdata: value[15:0], out_x[25:16], out_y[35:26]; tlast: last
// cfg_*   | in  | cfg_we, cfg_index, cfg_wdata (no read-back)
//
// A transaction with no pixel ready goes back to idle after the readiness check;
// else every one of the (2*RADIUS+1)^2 taps (49 at RADIUS 3) is a separate
// read of the RAM's single read port, and these reads dominate its duration.
// rst_n is synchronous, active low; counters, state and settings reset, the line
// store and data path do not. A result waits in the output register; a new input
// transaction is taken meanwhile and stalls only before its own result.
//
module separable_gaussian_blur_top #(
  parameter int RADIUS     = sgb_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sgb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sgb_pkg::PIX_W-1:0]       in_tdata,   // pixel
  input  logic                            in_tuser,   // kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sgb_pkg::OUT_DATA_W-1:0]  out_tdata,  // value, out_x, out_y, pad
  output logic                            out_tlast,  // last_of_frame
  input  logic                            cfg_we,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgb_pkg::COEFF_W-1:0]     cfg_wdata
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int DWW  = $clog2(MAX_WIDTH + 1);
  localparam int YW   = $clog2(MAX_HEIGHT + 1);
  localparam int AW   = $clog2(sgb_pkg::ROWS_KEPT * MAX_WIDTH);
  localparam int TW   = 3;
  localparam int PW   = 2 * sgb_pkg::PIX_W;
  localparam int HW   = PW + 3;
  localparam int VW   = HW + sgb_pkg::COEFF_W;
  localparam int ACCW = VW + 3;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_RUN   = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  // configuration
  logic [sgb_pkg::DIM_W-1:0]   fw_r, fh_r;
  logic [sgb_pkg::COEFF_W-1:0] c0_r, c1_r, c2_r, c3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= sgb_pkg::WIDTH_RST;
      fh_r <= sgb_pkg::HEIGHT_RST;
      c0_r <= sgb_pkg::C0_RST;
      c1_r <= sgb_pkg::C1_RST;
      c2_r <= sgb_pkg::C2_RST;
      c3_r <= sgb_pkg::C3_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgb_pkg::REG_WIDTH:  fw_r <= cfg_wdata[sgb_pkg::DIM_W-1:0];
        sgb_pkg::REG_HEIGHT: fh_r <= cfg_wdata[sgb_pkg::DIM_W-1:0];
        sgb_pkg::REG_C0:     c0_r <= cfg_wdata;
        sgb_pkg::REG_C1:     c1_r <= cfg_wdata;
        sgb_pkg::REG_C2:     c2_r <= cfg_wdata;
        sgb_pkg::REG_C3:     c3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective frame size, clamped to 1..MAX
  logic [31:0]    fw32, fh32, w32, h32;
  logic [DWW-1:0] w;
  logic [YW-1:0]  h;
  assign fw32 = {21'b0, fw_r};
  assign fh32 = {21'b0, fh_r};
  assign w32  = (fw32 == 32'd0) ? 32'd1 : (fw32 > 32'(MAX_WIDTH))  ? 32'(MAX_WIDTH)  : fw32;
  assign h32  = (fh32 == 32'd0) ? 32'd1 : (fh32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : fh32;
  assign w    = w32[DWW-1:0];
  assign h    = h32[YW-1:0];

  function automatic logic [sgb_pkg::COEFF_W-1:0] tap_weight(
    input logic signed [TW-1:0] d,
    input logic [sgb_pkg::COEFF_W-1:0] k0, k1, k2, k3
  );
    logic [TW-1:0] m;
    m = (d < 0) ? TW'(-d) : TW'(d);
    case (m[1:0])
      2'd0:    tap_weight = k0;
      2'd1:    tap_weight = k1;
      2'd2:    tap_weight = k2;
      default: tap_weight = k3;
    endcase
  endfunction

  // state
  state_t          state_r;
  logic [XW-1:0]   in_col_r, out_col_r;
  logic [YW-1:0]   in_row_r, out_row_r;
  logic signed [TW-1:0] ty_r, tx_r;
  logic            issue_done_r;

  // read pipeline tags
  logic            t1_v_r, t2_v_r, t3_v_r, t4_v_r;
  logic            t1_lx_r, t2_lx_r;
  logic            t1_ly_r, t2_ly_r, t3_ly_r, t4_ly_r;
  logic [sgb_pkg::COEFF_W-1:0] t1_wx_r, t1_wy_r, t2_wy_r, t3_wy_r;
  logic [sgb_pkg::PIX_W-1:0]   q_r;
  logic [PW-1:0]   prod_r;
  logic [HW-1:0]   hsum_r, hfin_r;
  logic [VW-1:0]   vprod_r;
  logic [ACCW-1:0] acc_r;

  // output register
  logic                  out_v_r;
  logic [sgb_pkg::PIX_W-1:0] o_val_r;
  logic [sgb_pkg::POS_W-1:0] o_x_r, o_y_r;
  logic                  o_last_r;

  // line store
  logic [sgb_pkg::PIX_W-1:0] mem [sgb_pkg::ROWS_KEPT * MAX_WIDTH];

  // accept path: clear stale counters, store the pixel, advance input position
  logic            accept;
  logic            stale;
  logic [XW-1:0]   ic_b, oc_b;
  logic [YW-1:0]   ir_b, or_b;
  logic            do_wr;
  logic [AW-1:0]   wr_addr;
  logic [XW:0]     ic_inc;
  logic [XW-1:0]   ic_new;
  logic [YW-1:0]   ir_new;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign stale     = (out_row_r >= h);
  assign ic_b      = stale ? '0 : in_col_r;
  assign ir_b      = stale ? '0 : in_row_r;
  assign oc_b      = stale ? '0 : out_col_r;
  assign or_b      = stale ? '0 : out_row_r;
  assign do_wr     = accept && !in_tuser && (ir_b < h);
  assign wr_addr   = AW'(ir_b[2:0]) * AW'(MAX_WIDTH) + AW'(ic_b);
  assign ic_inc    = {1'b0, ic_b} + 1'b1;

  always_comb begin
    ic_new = ic_b;
    ir_new = ir_b;
    if (do_wr) begin
      if ((XW+2)'(ic_inc) >= (XW+2)'(w)) begin
        ic_new = '0;
        ir_new = ir_b + 1'b1;
      end else begin
        ic_new = ic_inc[XW-1:0];
      end
    end
  end

  // readiness of the next output pixel
  logic [YW:0] need, hm1;
  logic        ready_px;
  assign hm1      = {1'b0, h} - 1'b1;
  assign need     = (({1'b0, out_row_r} + (YW+1)'(RADIUS)) > hm1) ? hm1
                    : ({1'b0, out_row_r} + (YW+1)'(RADIUS));
  assign ready_px = ({1'b0, in_row_r} > need);

  // tap address, clamped to the frame
  logic signed [YW+1:0]  ry_s;
  logic signed [DWW+1:0] cx_s;
  logic [2:0]            ry_slot;
  logic [XW-1:0]         cx;
  logic [YW-1:0]         hm1y;
  logic [DWW-1:0]        wm1;
  logic [AW-1:0]         rd_addr;
  logic                  issue;
  assign hm1y = h - 1'b1;
  assign wm1  = w - 1'b1;
  assign ry_s = $signed({2'b00, out_row_r}) + (YW+2)'(ty_r);
  assign cx_s = $signed({{(DWW+2-XW){1'b0}}, out_col_r}) + (DWW+2)'(tx_r);
  assign ry_slot = (ry_s < 0) ? 3'd0 :
                   (ry_s >= $signed({2'b00, h})) ? hm1y[2:0] : ry_s[2:0];
  assign cx      = (cx_s < 0) ? '0 :
                   (cx_s >= $signed({2'b00, w})) ? wm1[XW-1:0] : cx_s[XW-1:0];
  assign rd_addr = AW'(ry_slot) * AW'(MAX_WIDTH) + AW'(cx);
  assign issue   = (state_r == S_RUN) && !issue_done_r;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_addr] <= in_tdata;
    q_r <= mem[rd_addr];
  end

  // rounding and saturation of the finished sum
  logic [ACCW-1:0] rnd;
  logic [ACCW-33:0] rnd_int;
  logic [sgb_pkg::PIX_W-1:0] sat_val;
  assign rnd     = acc_r + ACCW'(33'h0_8000_0000);
  assign rnd_int = rnd[ACCW-1:32];
  assign sat_val = (rnd_int > (ACCW-32)'(16'hFFFF)) ? 16'hFFFF : rnd_int[15:0];

  // output position bookkeeping
  logic          last_px;
  logic [XW:0]   oc_inc;
  logic          load_out;
  assign last_px  = ((DWW+1)'(out_col_r) >= (DWW+1)'(wm1)) && (out_row_r >= hm1y);
  assign oc_inc   = {1'b0, out_col_r} + 1'b1;
  assign load_out = (state_r == S_FIN) && (!out_v_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      issue_done_r <= 1'b0;
      t1_v_r       <= 1'b0;
      t2_v_r       <= 1'b0;
      t3_v_r       <= 1'b0;
      t4_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      // output valid: set on load, cleared when the held result is taken
      if (load_out) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;

      // tap pipeline: read, weight, horizontal sum, vertical weight, accumulate
      t1_v_r  <= issue;
      t1_lx_r <= (tx_r == TW'(RADIUS));
      t1_ly_r <= (tx_r == TW'(RADIUS)) && (ty_r == TW'(RADIUS));
      t1_wx_r <= tap_weight(tx_r, c0_r, c1_r, c2_r, c3_r);
      t1_wy_r <= tap_weight(ty_r, c0_r, c1_r, c2_r, c3_r);

      t2_v_r  <= t1_v_r;
      t2_lx_r <= t1_lx_r;
      t2_ly_r <= t1_ly_r;
      t2_wy_r <= t1_wy_r;
      prod_r  <= q_r * t1_wx_r;

      t3_v_r <= t2_v_r && t2_lx_r;
      if (t2_v_r) begin
        if (t2_lx_r) begin
          hfin_r  <= hsum_r + HW'(prod_r);
          hsum_r  <= '0;
          t3_wy_r <= t2_wy_r;
          t3_ly_r <= t2_ly_r;
        end else begin
          hsum_r <= hsum_r + HW'(prod_r);
        end
      end

      t4_v_r  <= t3_v_r;
      t4_ly_r <= t3_ly_r;
      vprod_r <= hfin_r * t3_wy_r;
      if (t4_v_r) acc_r <= acc_r + ACCW'(vprod_r);

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            in_col_r  <= ic_new;
            in_row_r  <= ir_new;
            out_col_r <= oc_b;
            out_row_r <= or_b;
            state_r   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ready_px) begin
            ty_r         <= -TW'(RADIUS);
            tx_r         <= -TW'(RADIUS);
            issue_done_r <= 1'b0;
            hsum_r       <= '0;
            acc_r        <= '0;
            state_r      <= S_RUN;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_RUN: begin
          if (issue) begin
            if (tx_r == TW'(RADIUS)) begin
              tx_r <= -TW'(RADIUS);
              if (ty_r == TW'(RADIUS)) issue_done_r <= 1'b1;
              else ty_r <= ty_r + 1'b1;
            end else begin
              tx_r <= tx_r + 1'b1;
            end
          end
          if (t4_v_r && t4_ly_r) state_r <= S_FIN;
        end
        S_FIN: begin
          if (load_out) begin
            o_val_r  <= sat_val;
            o_x_r    <= sgb_pkg::POS_W'(out_col_r);
            o_y_r    <= sgb_pkg::POS_W'(out_row_r);
            o_last_r <= last_px;
            if (last_px) begin
              in_col_r  <= '0;
              in_row_r  <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
            end else if ((DWW+2)'(oc_inc) >= (DWW+2)'(w)) begin
              out_col_r <= '0;
              if ((out_row_r + 1'b1) >= h) begin
                in_col_r  <= '0;
                in_row_r  <= '0;
                out_row_r <= '0;
              end else begin
                out_row_r <= out_row_r + 1'b1;
              end
            end else begin
              out_col_r <= oc_inc[XW-1:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0, o_y_r, o_x_r, o_val_r};
  assign out_tlast  = o_last_r;

endmodule

// ===== bench/sgb_checker.sv =====
// ----------------------------------------------------------------------------
// sgb_checker
// Watches the pixel, result and register buses of the blur core, keeps its own
// copy of line store, counters and weights, predicts every blurred pixel and
// compares it with what the core hands out.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sgb_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [sgb_pkg::PIX_W-1:0]       in_tdata,   // pixel
  input  logic                            in_tuser,   // kind
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [sgb_pkg::OUT_DATA_W-1:0]  out_tdata,  // value, out_x, out_y, pad
  input  logic                            out_tlast,  // last_of_frame
  input  logic                            cfg_we,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgb_pkg::COEFF_W-1:0]     cfg_wdata,
  output int                              n_errors,
  output int                              n_pending
);

  localparam int RAD = sgb_pkg::RADIUS_DEF;

  typedef struct packed {
    logic [sgb_pkg::PIX_W-1:0] value;
    logic [sgb_pkg::POS_W-1:0] x;
    logic [sgb_pkg::POS_W-1:0] y;
    logic                      last;
  } blur_pix_t;

  blur_pix_t                   blurred_q[$];
  logic [sgb_pkg::PIX_W-1:0]   line_mem [0:sgb_pkg::ROWS_KEPT*sgb_pkg::MAX_WIDTH_DEF-1];
  int unsigned                 wr_col, wr_row, rd_col, rd_row;
  logic [sgb_pkg::DIM_W-1:0]   width_r, height_r;
  logic [sgb_pkg::COEFF_W-1:0] tap_w [0:3];
  int                          err_cnt;

  initial begin
    foreach (line_mem[i]) line_mem[i] = '0;
    err_cnt = 0;
  end

  function automatic int unsigned used_dim(logic [sgb_pkg::DIM_W-1:0] v,
                                           int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic int unsigned edge_pos(int p, int unsigned size);
    if (p < 0) return 0;
    if (p >= int'(size)) return size - 1;
    return unsigned'(p);
  endfunction

  function automatic int unsigned line_addr(int unsigned row, int unsigned col);
    return (row % sgb_pkg::ROWS_KEPT) * sgb_pkg::MAX_WIDTH_DEF + col;
  endfunction

  // one transaction into the blur; may push one expected pixel
  task automatic blur_step(input logic kind, input logic [sgb_pkg::PIX_W-1:0] pix);
    int unsigned w, h, need, ry, cx;
    logic [63:0] hsum, acc;
    blur_pix_t   res;
    w = used_dim(width_r, sgb_pkg::MAX_WIDTH_DEF);
    h = used_dim(height_r, sgb_pkg::MAX_HEIGHT_DEF);
    if (rd_row >= h) begin
      wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
    end
    if (kind == 1'b0 && wr_row < h) begin
      line_mem[line_addr(wr_row, wr_col)] = pix;
      wr_col++;
      if (wr_col >= w) begin
        wr_col = 0;
        wr_row++;
      end
    end
    need = rd_row + RAD;
    if (need > h - 1) need = h - 1;
    if (wr_row <= need) return;
    acc = '0;
    for (int dy = -RAD; dy <= RAD; dy++) begin
      ry = edge_pos(int'(rd_row) + dy, h);
      hsum = '0;
      for (int dx = -RAD; dx <= RAD; dx++) begin
        cx = edge_pos(int'(rd_col) + dx, w);
        hsum += 64'(line_mem[line_addr(ry, cx)]) * 64'(tap_w[dx < 0 ? -dx : dx]);
      end
      acc += hsum * 64'(tap_w[dy < 0 ? -dy : dy]);
    end
    acc = (acc + 64'h8000_0000) >> 32;
    res.value = (acc > 64'd65535) ? 16'hFFFF : acc[15:0];
    res.x     = rd_col[sgb_pkg::POS_W-1:0];
    res.y     = rd_row[sgb_pkg::POS_W-1:0];
    res.last  = (rd_col >= w - 1) && (rd_row >= h - 1);
    blurred_q.push_back(res);
    rd_col++;
    if (rd_col >= w) begin
      rd_col = 0;
      rd_row++;
    end
    if (res.last || rd_row >= h) begin
      wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
    end
  endtask

  always @(posedge clk) begin
    blur_pix_t got, want;
    if (!rst_n) begin
      wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
      width_r  = sgb_pkg::WIDTH_RST;
      height_r = sgb_pkg::HEIGHT_RST;
      tap_w[0] = sgb_pkg::C0_RST;
      tap_w[1] = sgb_pkg::C1_RST;
      tap_w[2] = sgb_pkg::C2_RST;
      tap_w[3] = sgb_pkg::C3_RST;
      blurred_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sgb_pkg::REG_WIDTH:  width_r  = cfg_wdata[sgb_pkg::DIM_W-1:0];
          sgb_pkg::REG_HEIGHT: height_r = cfg_wdata[sgb_pkg::DIM_W-1:0];
          sgb_pkg::REG_C0:     tap_w[0] = cfg_wdata;
          sgb_pkg::REG_C1:     tap_w[1] = cfg_wdata;
          sgb_pkg::REG_C2:     tap_w[2] = cfg_wdata;
          sgb_pkg::REG_C3:     tap_w[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) blur_step(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[15:0];
        got.x     = out_tdata[25:16];
        got.y     = out_tdata[35:26];
        got.last  = out_tlast;
        if (blurred_q.size() == 0) begin
          $display("%0t: unexpected result value=%0d x=%0d y=%0d last=%0b",
                   $time, got.value, got.x, got.y, got.last);
          err_cnt++;
        end else begin
          want = blurred_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch exp value=%0d x=%0d y=%0d last=%0b",
                     $time, want.value, want.x, want.y, want.last);
            $display("%0t:          act value=%0d x=%0d y=%0d last=%0b",
                     $time, got.value, got.x, got.y, got.last);
            err_cnt++;
          end
        end
      end
    end
    n_errors  <= err_cnt;
    n_pending <= blurred_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Frame-level stimulus for the separable Gaussian blur core: directed corner
// frames, then random small frames plus a max-height frame, under four
// handshake pressure modes. Checking lives in sgb_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int WDOG_LIMIT    = 20000;  // quiet cycles before giving up
  localparam int SETTLE_CYC    = 120;    // > one full 49-tap result
  localparam int RAND_ITEMS    = 1350;
  localparam int RESERVE_ITEMS = 1080;   // left for the max-height and closing frames

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [sgb_pkg::PIX_W-1:0]      in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [sgb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tlast;
  logic                           cfg_we = 1'b0;
  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_index = sgb_pkg::REG_WIDTH;
  logic [sgb_pkg::COEFF_W-1:0]    cfg_wdata = '0;

  int n_errors, n_pending;
  int send_idle_pct = 0;   // chance of a sender gap cycle
  int recv_stall_pct = 0;  // chance of out_tready low
  int items_sent = 0;
  int frames_run = 0;
  int quiet_cyc = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  separable_gaussian_blur_top uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  sgb_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_we, .cfg_index, .cfg_wdata,
    .n_errors, .n_pending
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog: any accepted transaction resets it
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cyc <= 0;
      else quiet_cyc <= quiet_cyc + 1;
      if (quiet_cyc >= WDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, n_pending);
        $display("[separable_gaussian_blur_top] ERROR");
        $finish;
      end
    end
  end

  function automatic int used_dim(int v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  // mode 0 none, 1 sender gaps, 2 receiver stalls, 3 both lightly
  task automatic set_pressure(input int mode);
    case (mode)
      1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  task automatic send_item(input logic kind, input logic [sgb_pkg::PIX_W-1:0] pix);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic drain_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_regs(input int w, input int h, input int c0, input int c1,
                            input int c2, input int c3);
    sgb_pkg::cfg_reg_t idx [6];
    int                val [6];
    idx = '{sgb_pkg::REG_WIDTH, sgb_pkg::REG_HEIGHT, sgb_pkg::REG_C0,
            sgb_pkg::REG_C1, sgb_pkg::REG_C2, sgb_pkg::REG_C3};
    val = '{w, h, c0, c1, c2, c3};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i][sgb_pkg::COEFF_W-1:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [sgb_pkg::PIX_W-1:0] pick_pixel(input int style);
    case (style)
      1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One frame. Before pixel W*min(4,H) nothing can be ready, so early drains
  // there produce nothing; after all pixels every item yields one result.
  task automatic run_frame(input int w_raw, input int h_raw, input int c0, input int c1,
                           input int c2, input int c3, input int style, input int mode);
    int w, h, ready_at, tail;
    w = used_dim(w_raw);
    h = used_dim(h_raw);
    ready_at = w * ((h < 4) ? h : 4);
    write_regs(w_raw, h_raw, c0, c1, c2, c3);
    set_pressure(mode);
    for (int k = 0; k < w * h; k++) begin
      if (k < ready_at && $urandom_range(0, 7) == 0)
        send_item(1'b1, 16'($urandom_range(0, 65535)));
      send_item(1'b0, pick_pixel(style));
    end
    // tail: drains, with pixel noise that the core drops
    tail = ready_at - 1;
    for (int k = 0; k < tail; k++)
      send_item(($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1, 16'($urandom_range(0, 65535)));
    // a drain with nothing pending
    if ($urandom_range(0, 3) == 0) send_item(1'b1, 16'($urandom_range(0, 65535)));
    frames_run++;
    drain_idle();
  endtask

  initial begin
    int mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: degenerate 1x1 from zero sizes, then a trailing empty drain
    run_frame(0, 0, 17430, 13956, 7166, 2359, 0, 0);
    set_pressure(0);
    send_item(1'b1, 16'h0000);
    drain_idle();
    // saturation with all weights full scale
    run_frame(3, 2, 65535, 65535, 65535, 65535, 2, 0);
    // all weights zero, extreme pixels
    run_frame(2, 1, 0, 0, 0, 0, 1, 3);
    // rounding pattern, single column
    run_frame(1, 3, 32768, 1, 0, 65535, 1, 2);

    // random frames; pressure mode rotates per frame
    while (items_sent < RAND_ITEMS - RESERVE_ITEMS) begin
      mode = frames_run % 4;
      run_frame($urandom_range(1, 12), $urandom_range(1, 10),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 2), mode);
    end
    // oversized register falls back to the maximum
    run_frame(1, 2047, $urandom_range(0, 65535), $urandom_range(0, 20000),
              $urandom_range(0, 20000), $urandom_range(0, 20000), 0, 1);
    // back to reset weights
    run_frame(5, 5, sgb_pkg::C0_RST, sgb_pkg::C1_RST, sgb_pkg::C2_RST,
              sgb_pkg::C3_RST, 0, 0);

    $display("Covered %0d frames, %0d input transactions, four pressure modes,", frames_run,
             items_sent);
    $display("size registers at zero and above maximum, weights at zero and full scale.");
    if (n_errors == 0 && n_pending == 0) begin
      $display("[separable_gaussian_blur_top] OK");
    end else begin
      $display("[separable_gaussian_blur_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sgb_pkg.sv
rtl/core/separable_gaussian_blur_top.sv
bench/sgb_checker.sv
bench/tb_top.sv
